// File: design/gdr_pkg.sv
// Shared types, codes and arithmetic helpers for the gated delta-rule core.
`timescale 1ns / 1ps
package gdr_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PROC = 1'b1;

  localparam logic [1:0] REG_KEY_LENGTH     = 2'd0;
  localparam logic [1:0] REG_KEY_HEAD_COUNT = 2'd1;
  localparam logic [1:0] REG_QUERY_SCALE    = 2'd2;

  localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

  typedef struct packed {
    logic              op;
    logic [3:0]        head;
    logic [6:0]        element;
    logic signed [15:0] key_elem;
    logic signed [15:0] query_elem;
    logic signed [15:0] value_elem;
    logic [15:0]       decay;
    logic [15:0]       update_gain;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_head;
    logic [6:0]         out_element;
    logic signed [31:0] out_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  key_length;
    logic [4:0]  key_head_count;
    logic [15:0] query_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PASS,
    ST_DRAIN,
    ST_SCALE_X,
    ST_SCALE_P,
    ST_SCALE_R
  } back_state_t;

  // Round half toward +infinity, then arithmetic shift right.
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] x,
                                                   input int unsigned n);
    return (x + (66'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > SAT_MAX) return 32'sh7FFF_FFFF;
    if (x < SAT_MIN) return -32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

// File: design/gdr_front.sv
// Input side: range check of incoming beats and a two-entry command queue.
`timescale 1ns / 1ps
module gdr_front #(
  parameter int MAX_KEY_DIM = 128,
  parameter int VALUE_DIM   = 128,
  parameter int VALUE_HEADS = 16,
  parameter int KEY_HEADS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gdr_pkg::in_item_t in_data,
  input  logic              clearing,
  output logic              q_valid,
  output gdr_pkg::in_item_t q_item,
  input  logic              q_pop
);

  gdr_pkg::in_item_t fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       in_range;
  logic       push;
  logic       pop;

  always_comb begin
    if (in_data.op == gdr_pkg::OP_LOAD) begin
      in_range = (32'(in_data.head) < KEY_HEADS) && (32'(in_data.element) < MAX_KEY_DIM);
    end else begin
      in_range = (32'(in_data.head) < VALUE_HEADS) && (32'(in_data.element) < VALUE_DIM);
    end
  end

  // Out-of-range beats are accepted and dropped here.
  assign in_ready = (count_r != 2'd2) && !clearing;
  assign push     = in_valid && in_ready && in_range;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= in_data;
  end

endmodule

// File: design/gdr_back.sv
// Execution side: key/query store, state memory, two-pass row pipeline, scaling.
`timescale 1ns / 1ps
module gdr_back #(
  parameter int MAX_KEY_DIM = 128,
  parameter int VALUE_DIM   = 128,
  parameter int VALUE_HEADS = 16,
  parameter int KEY_HEADS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gdr_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  gdr_pkg::in_item_t  q_item,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output gdr_pkg::out_item_t out_data
);

  localparam int STATE_DEPTH = VALUE_HEADS * VALUE_DIM * MAX_KEY_DIM;
  localparam int KQ_DEPTH    = KEY_HEADS * MAX_KEY_DIM;
  localparam int STATE_AW    = $clog2(STATE_DEPTH);
  localparam int KQ_AW       = $clog2(KQ_DEPTH);
  localparam int LEN_W       = $clog2(MAX_KEY_DIM + 1);

  gdr_pkg::back_state_t state_r, state_nxt;

  logic [31:0] st_mem [STATE_DEPTH];
  logic [31:0] kq_mem [KQ_DEPTH];

  logic [STATE_AW-1:0] clr_cnt_r;
  gdr_pkg::in_item_t   item_r;
  logic [3:0]          hk_r;
  logic [STATE_AW-1:0] row_base_r;
  logic [KQ_AW-1:0]    kbase_r;
  logic [LEN_W-1:0]    k_r;
  logic                pass_r;
  logic signed [63:0]  acc_r;
  logic signed [31:0]  delta_r;
  logic signed [31:0]  res_r;
  logic signed [47:0]  x_r;
  logic signed [41:0]  plo_r;
  logic signed [40:0]  phi_r;
  logic                out_valid_r;
  gdr_pkg::out_item_t  out_data_r;

  // Row pipeline: read, first multiply, round/saturate/write, second multiply, accumulate.
  logic                v1_r, v2_r, v3_r, v4_r;
  logic [31:0]         st_q_r;
  logic [31:0]         kq_q_r;
  logic [STATE_AW-1:0] a1_r, a2_r;
  logic signed [48:0]  m1_r;
  logic signed [31:0]  st1_r;
  logic [31:0]         kq1_r, kq2_r;
  logic signed [31:0]  u_r;
  logic signed [47:0]  m2_r;

  logic [LEN_W-1:0]    len;
  logic [4:0]          cnt;
  logic                issue;
  logic                kq_we;
  logic                emit;
  logic                pipe_busy;
  logic                last_k;
  logic signed [31:0]  a_op;
  logic signed [16:0]  b_op;
  logic signed [48:0]  m1_nxt;
  logic signed [31:0]  u_nxt;
  logic signed [15:0]  m2_sel;
  logic [15:0]         gain_sel;
  logic signed [65:0]  x_nxt;
  logic signed [65:0]  scaled;
  logic signed [31:0]  scale_res;
  logic                st_we;
  logic [STATE_AW-1:0] st_waddr;
  logic [31:0]         st_wdata;

  assign len = (32'(cfg.key_length) > MAX_KEY_DIM) ? LEN_W'(MAX_KEY_DIM)
                                                    : LEN_W'(cfg.key_length);
  always_comb begin
    if (cfg.key_head_count == 5'd0) begin
      cnt = 5'd1;
    end else if (32'(cfg.key_head_count) > KEY_HEADS) begin
      cnt = 5'(KEY_HEADS);
    end else begin
      cnt = cfg.key_head_count;
    end
  end

  assign clearing  = (state_r == gdr_pkg::ST_CLEAR);
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;
  assign last_k    = (LEN_W'(k_r + 1'b1) == len);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    kq_we     = 1'b0;
    issue     = 1'b0;
    emit      = 1'b0;
    case (state_r)
      gdr_pkg::ST_CLEAR: begin
        if (clr_cnt_r == STATE_AW'(STATE_DEPTH - 1)) state_nxt = gdr_pkg::ST_IDLE;
      end
      gdr_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == gdr_pkg::OP_LOAD) begin
            kq_we = 1'b1;
          end else begin
            state_nxt = gdr_pkg::ST_MOD;
          end
        end
      end
      gdr_pkg::ST_MOD: begin
        if (5'(hk_r) < cnt) state_nxt = gdr_pkg::ST_PASS;
      end
      gdr_pkg::ST_PASS: begin
        if (len == '0) begin
          state_nxt = gdr_pkg::ST_DRAIN;
        end else begin
          issue = 1'b1;
          if (last_k) state_nxt = gdr_pkg::ST_DRAIN;
        end
      end
      gdr_pkg::ST_DRAIN: begin
        if (!pipe_busy) state_nxt = gdr_pkg::ST_SCALE_X;
      end
      gdr_pkg::ST_SCALE_X: state_nxt = gdr_pkg::ST_SCALE_P;
      gdr_pkg::ST_SCALE_P: state_nxt = gdr_pkg::ST_SCALE_R;
      gdr_pkg::ST_SCALE_R: begin
        if (!pass_r) begin
          state_nxt = gdr_pkg::ST_PASS;
        end else if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = gdr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdr_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // First multiply: decay on the first pass, key times delta on the second.
  assign a_op   = pass_r ? delta_r : $signed(st_q_r);
  assign b_op   = pass_r ? $signed({kq_q_r[31], kq_q_r[31:16]}) : $signed({1'b0, item_r.decay});
  assign m1_nxt = a_op * b_op;

  always_comb begin
    if (pass_r) begin
      u_nxt = gdr_pkg::sat32(gdr_pkg::rnd_shift(66'(m1_r), 12) + 66'(st1_r));
    end else begin
      u_nxt = gdr_pkg::sat32(gdr_pkg::rnd_shift(66'(m1_r), 15));
    end
  end

  // The first pass dots with the key, the second with the query.
  assign m2_sel = pass_r ? $signed(kq2_r[15:0]) : $signed(kq2_r[31:16]);

  assign gain_sel = pass_r ? cfg.query_scale : item_r.update_gain;
  always_comb begin
    if (pass_r) begin
      x_nxt = gdr_pkg::rnd_shift(66'(acc_r), 12);
    end else begin
      x_nxt = 66'($signed({item_r.value_elem, 4'b0000})) - gdr_pkg::rnd_shift(66'(acc_r), 12);
    end
  end
  assign scaled    = (66'(phi_r) <<< 24) + 66'(plo_r);
  assign scale_res = gdr_pkg::sat32(gdr_pkg::rnd_shift(scaled, 15));

  assign st_we    = clearing || v2_r;
  assign st_waddr = clearing ? clr_cnt_r : a2_r;
  assign st_wdata = clearing ? 32'd0 : u_nxt;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_q_r <= st_mem[row_base_r + STATE_AW'(k_r)];
  end

  always_ff @(posedge clk) begin
    if (kq_we) begin
      kq_mem[KQ_AW'(32'(q_item.head) * MAX_KEY_DIM + 32'(q_item.element))] <=
        {q_item.key_elem, q_item.query_elem};
    end
    kq_q_r <= kq_mem[kbase_r + KQ_AW'(k_r)];
  end

  always_ff @(posedge clk) begin
    a1_r  <= row_base_r + STATE_AW'(k_r);
    m1_r  <= m1_nxt;
    st1_r <= $signed(st_q_r);
    kq1_r <= kq_q_r;
    a2_r  <= a1_r;
    u_r   <= u_nxt;
    kq2_r <= kq1_r;
    m2_r  <= u_r * m2_sel;
    if (v4_r) acc_r <= acc_r + 64'(m2_r);

    case (state_r)
      gdr_pkg::ST_IDLE: begin
        if (q_valid && q_item.op == gdr_pkg::OP_PROC) begin
          item_r     <= q_item;
          hk_r       <= q_item.head;
          row_base_r <= STATE_AW'((32'(q_item.head) * VALUE_DIM + 32'(q_item.element))
                                  * MAX_KEY_DIM);
          pass_r     <= 1'b0;
          k_r        <= '0;
          acc_r      <= '0;
        end
      end
      gdr_pkg::ST_MOD: begin
        // Key head is the value head modulo the head count, one subtraction a cycle.
        if (5'(hk_r) >= cnt) begin
          hk_r <= hk_r - cnt[3:0];
        end else begin
          kbase_r <= KQ_AW'(32'(hk_r) * MAX_KEY_DIM);
        end
      end
      gdr_pkg::ST_PASS: begin
        if (issue) k_r <= k_r + 1'b1;
      end
      gdr_pkg::ST_SCALE_X: x_r <= x_nxt[47:0];
      gdr_pkg::ST_SCALE_P: begin
        plo_r <= $signed({1'b0, x_r[23:0]}) * $signed({1'b0, gain_sel});
        phi_r <= $signed(x_r[47:24]) * $signed({1'b0, gain_sel});
      end
      gdr_pkg::ST_SCALE_R: begin
        if (!pass_r) begin
          delta_r <= scale_res;
          pass_r  <= 1'b1;
          k_r     <= '0;
          acc_r   <= '0;
        end
      end
      default: ;
    endcase

    if (emit) begin
      out_data_r.out_head    <= item_r.head;
      out_data_r.out_element <= item_r.element;
      out_data_r.out_value   <= scale_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !v2_r)
    else $error("row pipeline active during clearing pass");
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdr_pkg::ST_IDLE) |-> !pipe_busy)
    else $error("row pipeline busy while idle");
  a_issue_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> $past(state_r == gdr_pkg::ST_PASS))
    else $error("read issued outside a pass");
  a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdr_pkg::ST_SCALE_X) |-> !pipe_busy)
    else $error("scaling started before the pass drained");
`endif

endmodule

// File: design/gated_delta_rule_state_update_core.sv
// Top level: configuration registers, front queue and execution back end.
// Flow: a load beat goes into the key/query store in the cycle the back end pops it.
// A process beat first reduces its head modulo the key head count, then makes two passes
// over its state row through the state memory, each followed by a drain and the scaling
// states SCALE_X, SCALE_P and SCALE_R; out_valid rises once the second pass is scaled and
// the output register is free. The back end takes no new beat until then; loads go at one
// per cycle while it is idle.
// Reset: synchronous, active low; afterwards the state memory is cleared one entry a
// cycle over all VALUE_HEADS*VALUE_DIM*MAX_KEY_DIM entries, and in_ready is low meanwhile.
`timescale 1ns / 1ps
module gated_delta_rule_state_update_core #(
  parameter int MAX_KEY_DIM = 128,
  parameter int VALUE_DIM   = 128,
  parameter int VALUE_HEADS = 16,
  parameter int KEY_HEADS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gdr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gdr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  gdr_pkg::cfg_t     cfg_r;
  logic              clearing;
  logic              q_valid;
  logic              q_pop;
  gdr_pkg::in_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_length     <= 8'd128;
      cfg_r.key_head_count <= 5'd16;
      cfg_r.query_scale    <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        gdr_pkg::REG_KEY_LENGTH:     cfg_r.key_length     <= cfg_data[7:0];
        gdr_pkg::REG_KEY_HEAD_COUNT: cfg_r.key_head_count <= cfg_data[4:0];
        gdr_pkg::REG_QUERY_SCALE:    cfg_r.query_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  gdr_front #(
    .MAX_KEY_DIM (MAX_KEY_DIM),
    .VALUE_DIM   (VALUE_DIM),
    .VALUE_HEADS (VALUE_HEADS),
    .KEY_HEADS   (KEY_HEADS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  gdr_back #(
    .MAX_KEY_DIM (MAX_KEY_DIM),
    .VALUE_DIM   (VALUE_DIM),
    .VALUE_HEADS (VALUE_HEADS),
    .KEY_HEADS   (KEY_HEADS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
